// File: design/xrg_pkg.sv
`default_nettype none

package xrg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] GOLDEN_SEED = 32'h9E37_79B9;

  // command codes
  localparam logic CMD_RAW    = 1'b0;
  localparam logic CMD_RANGED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } xrg_state_e;

  typedef logic [WORD_W-1:0] word_t;

  // one xorshift step, shifts 13 / 17 / 5
  function automatic word_t xs_step(input word_t x);
    word_t t;
    t = x;
    t = t ^ (t << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/xrg_if.sv
`default_nettype none

// request channel
interface xrg_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic signed [xrg_pkg::WORD_W-1:0]  low_bound;
  logic signed [xrg_pkg::WORD_W-1:0]  high_bound;

  modport source (output valid, command, low_bound, high_bound, input ready);
  modport sink   (input valid, command, low_bound, high_bound, output ready);
endinterface

// result channel
interface xrg_res_if;
  logic                               valid;
  logic                               ready;
  logic        [xrg_pkg::WORD_W-1:0]  raw_word;
  logic signed [xrg_pkg::WORD_W-1:0]  ranged_value;
  logic        [xrg_pkg::WORD_W-1:0]  state_word;
  logic                               advanced;

  modport source (output valid, raw_word, ranged_value, state_word, advanced, input ready);
  modport sink   (input valid, raw_word, ranged_value, state_word, advanced, output ready);
endinterface

// seed write channel
interface xrg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic        [xrg_pkg::WORD_W-1:0]  seed_value;

  modport source (output valid, seed_value, input ready);
  modport sink   (input valid, seed_value, output ready);
endinterface

`default_nettype wire

// File: design/xorshift32_range_generator.sv
// From accept to result: raw draws and empty-span ranged draws go straight to the load out;
// a full-range draw takes the final add first. Other ranged draws: the accepting edge steps
// the generator, then the restoring divider runs (one quotient bit per cycle), then the final
// add, then the load out.
// Throughput: one item at a time; the request channel is ready again the cycle after the result
// is loaded and no seed write is offered.
// Reset: asynchronous, active low; generator state returns to 0x9E3779B9, all channels idle.
`default_nettype none

module xorshift32_range_generator (
  input wire logic clk_i,
  input wire logic rst_ni,
  xrg_cmd_if.sink   cmd_i,
  xrg_res_if.source res_o,
  xrg_cfg_if.sink   cfg_i
);
  import xrg_pkg::*;

  // sequencer
  xrg_state_e state_q, state_d;

  // generator state
  word_t gen_q, gen_d;

  // work registers for the item in flight
  word_t             lo_q, lo_d;
  word_t             span_q, span_d;
  word_t             div_q, div_d;      // dividend, shifted out MSB first
  word_t             rem_q, rem_d;      // partial remainder
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  word_t             wraw_q, wraw_d;
  word_t             wrng_q, wrng_d;
  logic              wadv_q, wadv_d;

  // output register
  logic  res_valid_q, res_valid_d;
  word_t res_raw_q, res_raw_d;
  word_t res_rng_q, res_rng_d;
  word_t res_st_q, res_st_d;
  logic  res_adv_q, res_adv_d;

  // divider unit: one 33-bit trial subtract for the remainder
  logic [WORD_W:0] trial_rem;
  logic [WORD_W:0] trial_diff;

  // request decode
  word_t xs_next;
  word_t req_lo, req_hi, req_span;
  logic  req_empty;
  logic  cmd_acc, cfg_acc;

  assign xs_next   = xs_step(gen_q);
  assign req_lo    = word_t'(cmd_i.low_bound);
  assign req_hi    = word_t'(cmd_i.high_bound);
  assign req_span  = req_hi - req_lo + word_t'(1);
  assign req_empty = (cmd_i.high_bound <= cmd_i.low_bound);

  // configuration takes priority; neither is taken mid-item
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign cmd_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  assign trial_rem  = {rem_q, div_q[WORD_W-1]};
  assign trial_diff = trial_rem - {1'b0, span_q};

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    lo_d        = lo_q;
    span_d      = span_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    wraw_d      = wraw_q;
    wrng_d      = wrng_q;
    wadv_d      = wadv_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_raw_d   = res_raw_q;
    res_rng_d   = res_rng_q;
    res_st_d    = res_st_q;
    res_adv_d   = res_adv_q;

    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          // zero seed would lock the generator at zero
          gen_d = (cfg_i.seed_value != '0) ? cfg_i.seed_value : GOLDEN_SEED;
        end else if (cmd_acc) begin
          lo_d = req_lo;
          if (cmd_i.command == CMD_RAW) begin
            gen_d   = xs_next;
            wraw_d  = xs_next;
            wrng_d  = '0;
            wadv_d  = 1'b1;
            state_d = ST_OUT;
          end else if (req_empty) begin
            wraw_d  = gen_q;
            wrng_d  = req_lo;
            wadv_d  = 1'b0;
            state_d = ST_OUT;
          end else begin
            gen_d  = xs_next;
            wraw_d = xs_next;
            wadv_d = 1'b1;
            if (req_span == '0) begin
              // full range: span wrapped, add the word directly
              rem_d   = xs_next;
              state_d = ST_FIX;
            end else begin
              span_d  = req_span;
              div_d   = xs_next;
              rem_d   = '0;
              cnt_d   = CNT_W'(WORD_W - 1);
              state_d = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        if (!trial_diff[WORD_W]) begin
          rem_d = trial_diff[WORD_W-1:0];
        end else begin
          rem_d = trial_rem[WORD_W-1:0];
        end
        div_d = {div_q[WORD_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end

      ST_FIX: begin
        wrng_d  = lo_q + rem_q;
        state_d = ST_OUT;
      end

      ST_OUT: begin
        // load once the output register is free or being drained
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_raw_d   = wraw_q;
          res_rng_d   = wrng_q;
          res_st_d    = gen_q;
          res_adv_d   = wadv_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= GOLDEN_SEED;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    span_q    <= span_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    wraw_q    <= wraw_d;
    wrng_q    <= wrng_d;
    wadv_q    <= wadv_d;
    res_raw_q <= res_raw_d;
    res_rng_q <= res_rng_d;
    res_st_q  <= res_st_d;
    res_adv_q <= res_adv_d;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.raw_word     = res_raw_q;
  assign res_o.ranged_value = signed'(res_rng_q);
  assign res_o.state_word   = res_st_q;
  assign res_o.advanced     = res_adv_q;

endmodule

`default_nettype wire

// File: design/xrg_checker.sv
`default_nettype none

module xrg_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cmd_valid_i,
  input wire logic                         cmd_ready_i,
  input wire logic                         res_valid_i,
  input wire logic                         res_ready_i,
  input wire logic [xrg_pkg::WORD_W-1:0]   res_raw_i,
  input wire logic [xrg_pkg::WORD_W-1:0]   res_state_i
);

  // result held until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_raw_i))
    else $error("result dropped or changed while stalled");

  // raw word always matches reported state
  a_raw_is_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_raw_i == res_state_i)
    else $error("raw word differs from state word");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("request taken while an item is in work");

  // an accepted item yields no result in the very next cycle unless one was already pending
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && (!res_valid_i || res_ready_i) |=> !res_valid_i)
    else $error("result appeared too early");

endmodule

bind xorshift32_range_generator xrg_checker u_xrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_raw_i   (res_o.raw_word),
  .res_state_i (res_o.state_word)
);

`default_nettype wire

// File: verif/tb_xorshift32_range_generator.sv
`default_nettype none

module tb_xorshift32_range_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RESET_LEN   = 7;
  // Cycles without any handshake before the run is declared hung. It covers the slowest item,
  // the longest sender gap and a long receiver stall, with a wide margin.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_LEN  = 40;
  localparam int unsigned RANDOM_LEN  = 1000;

  localparam word_t INT_MIN = 32'h8000_0000;
  localparam word_t INT_MAX = 32'h7FFF_FFFF;

  // receiver behaviour, switched to a random mode whenever the current mode runs out
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_MOSTLY_READY,
    RX_MOSTLY_STALLED,
    RX_LONG_RUNS
  } rx_mode_e;

  typedef struct packed {
    word_t raw_word;
    word_t ranged_value;
    word_t state_word;
    logic  advanced;
  } draw_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  xrg_cmd_if cmd_if ();
  xrg_res_if res_if ();
  xrg_cfg_if cfg_if ();

  xorshift32_range_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Our own copy of the generator state and the draws still owed by the block.
  word_t        gen_word = GOLDEN_SEED;
  draw_result_t pending_draws [$];

  int unsigned error_count = 0;
  int unsigned n_checked   = 0;
  int unsigned n_raw       = 0;
  int unsigned n_ranged    = 0;
  int unsigned n_empty     = 0;
  int unsigned n_full      = 0;
  int unsigned n_seeds     = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_count  = 0;

  // xorshift32 step, shifts 13 / 17 / 5
  function automatic word_t xorshift_next(input word_t x);
    word_t v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  // Works out the result of one request and moves our state on as the block should.
  function automatic draw_result_t predict_draw(input logic cmd, input word_t lo,
                                                input word_t hi);
    draw_result_t r;
    word_t        span;
    r.ranged_value = '0;
    r.advanced     = 1'b1;
    if (cmd == CMD_RANGED && $signed(hi) <= $signed(lo)) begin
      // empty span: state untouched, low bound returned
      r.raw_word     = gen_word;
      r.ranged_value = lo;
      r.advanced     = 1'b0;
    end else begin
      gen_word   = xorshift_next(gen_word);
      r.raw_word = gen_word;
      if (cmd == CMD_RANGED) begin
        span = hi - lo + 1;
        // full range wraps the span to zero: the raw word is added as it is
        r.ranged_value = (span == '0) ? lo + gen_word : lo + gen_word % span;
      end
    end
    r.state_word = gen_word;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Bursts of random length, then a gap. Now and then a long stretch with no gap at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
    gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
    cmd_if.valid <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  // Offers one item, predicts its result once accepted. Valid is left high for
  // the next item unless pacing opens a gap.
  task automatic send_draw(input logic cmd, input word_t lo, input word_t hi);
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.low_bound  <= lo;
    cmd_if.high_bound <= hi;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_draws.push_back(predict_draw(cmd, lo, hi));
    if (cmd == CMD_RAW) begin
      n_raw++;
    end else begin
      n_ranged++;
      if ($signed(hi) <= $signed(lo)) begin
        n_empty++;
      end else if (lo == INT_MIN && hi == INT_MAX) begin
        n_full++;
      end
    end
    @(negedge clk_i);
    pace_sender();
  endtask

  // Holds the sender off until every owed result has been taken.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
  endtask

  // Seed loads only with the block idle.
  task automatic write_seed(input word_t seed);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.seed_value <= seed;
    do @(posedge clk_i); while (!cfg_if.ready);
    gen_word = (seed != '0) ? seed : GOLDEN_SEED;
    n_seeds++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Raw draws straight from the reset state; bounds are don't-care but must not leak.
  task automatic test_reset_state();
    send_draw(CMD_RAW, INT_MIN, INT_MAX);
    send_draw(CMD_RAW, '1, '0);
    send_draw(CMD_RAW, '0, '0);
  endtask

  // Zero seed falls back to the golden constant; all-ones and single-bit seeds too.
  task automatic test_seed_loading();
    write_seed('0);
    send_draw(CMD_RAW, '0, '0);
    write_seed('1);
    send_draw(CMD_RAW, '0, '0);
    write_seed(32'h0000_0001);
    send_draw(CMD_RANGED, 32'd0, 32'd9);
    write_seed(INT_MIN);
    send_draw(CMD_RAW, '1, '1);
  endtask

  // Bound extremes: equal and inverted bounds, full range, spans of 2, 2^31, 2^31+1, 2^32-1.
  task automatic test_ranged_bounds();
    send_draw(CMD_RANGED, '0, '0);
    send_draw(CMD_RANGED, INT_MAX, INT_MIN);
    send_draw(CMD_RANGED, INT_MIN, INT_MIN);
    send_draw(CMD_RANGED, INT_MAX, INT_MAX);
    send_draw(CMD_RANGED, 32'd5, 32'd4);
    send_draw(CMD_RANGED, INT_MIN, INT_MAX);
    send_draw(CMD_RANGED, INT_MIN, INT_MIN + 1);
    send_draw(CMD_RANGED, INT_MAX - 1, INT_MAX);
    send_draw(CMD_RANGED, '1, '0);
    send_draw(CMD_RANGED, '0, INT_MAX);
    send_draw(CMD_RANGED, INT_MIN, '0);
    send_draw(CMD_RANGED, INT_MIN + 1, INT_MAX);
    send_draw(CMD_RAW, INT_MIN, INT_MAX);
  endtask

  // Mixed draws over eight seed phases; one phase pauses mid-way until all results are in.
  task automatic test_random_draws(input int unsigned total);
    logic        cmd;
    word_t       lo;
    word_t       hi;
    int unsigned sel;
    int unsigned per_phase;
    per_phase = total / 8;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      write_seed((phase == 1) ? '0 : (phase == 2) ? '1 : word_t'($urandom));
      for (int unsigned i = 0; i < per_phase; i++) begin
        cmd = ($urandom_range(0, 99) < 35) ? CMD_RAW : CMD_RANGED;
        lo  = $urandom;
        hi  = $urandom;
        sel = $urandom_range(0, 9);
        if (cmd == CMD_RANGED) begin
          if (sel < 4) begin
            hi = lo + $urandom_range(1, 64);
          end else if (sel == 4) begin
            hi = lo - $urandom_range(0, 3);
          end else if (sel == 5) begin
            lo = INT_MIN;
            hi = INT_MAX;
          end else if (sel == 6) begin
            hi = lo + ((word_t'(1) << $urandom_range(0, 31)) - 1);
          end else if (sel == 7) begin
            lo = INT_MIN + $urandom_range(0, 15);
            hi = INT_MAX - $urandom_range(0, 15);
          end
        end
        send_draw(cmd, lo, hi);
        if (phase == 4 && i == per_phase / 2) begin
          drain_results();
        end
      end
    end
  endtask

  // Receiver ready pattern, independent of the sender.
  initial begin : result_stall_pattern
    rx_mode_e    stall_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    stall_mode   = RX_STREAM;
    mode_left    = 0;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(64, 256);
      end
      mode_left--;
      case (stall_mode)
        RX_STREAM: begin
          res_if.ready <= 1'b1;
        end
        RX_MOSTLY_READY: begin
          res_if.ready <= ($urandom_range(0, 3) != 0);
        end
        RX_MOSTLY_STALLED: begin
          res_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (hold_left == 0) begin
            hold_left    = $urandom_range(1, 20);
            res_if.ready <= ~res_if.ready;
          end else begin
            hold_left--;
          end
        end
      endcase
    end
  end

  // Each accepted result against the oldest prediction, field by field.
  always @(posedge clk_i) begin : result_checker
    draw_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_checked++;
      if (pending_draws.size() == 0) begin
        report_error($sformatf("result with nothing owed: raw %h state %h",
                               res_if.raw_word, res_if.state_word));
      end else begin
        want = pending_draws.pop_front();
        if (res_if.raw_word !== want.raw_word)
          report_error($sformatf("raw_word %h, predicted %h", res_if.raw_word,
                                 want.raw_word));
        if (res_if.ranged_value !== want.ranged_value)
          report_error($sformatf("ranged_value %h, predicted %h", res_if.ranged_value,
                                 want.ranged_value));
        if (res_if.state_word !== want.state_word)
          report_error($sformatf("state_word %h, predicted %h", res_if.state_word,
                                 want.state_word));
        if (res_if.advanced !== want.advanced)
          report_error($sformatf("advanced %b, predicted %b", res_if.advanced,
                                 want.advanced));
      end
    end
  end

  // Hang detector: any handshake on any channel resets the count.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles, %0d results owed", $time,
               idle_count, pending_draws.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_RAW;
    cmd_if.low_bound  = '0;
    cmd_if.high_bound = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.seed_value = '0;
    rst_ni            = 1'b0;
    repeat (RESET_LEN) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_seed_loading();
    test_ranged_bounds();
    test_random_draws(RANDOM_LEN);

    drain_results();
    repeat (SETTLE_LEN) @(negedge clk_i);

    $display("Run covered %0d raw and %0d ranged draws (%0d empty spans, %0d full range)",
             n_raw, n_ranged, n_empty, n_full);
    $display("across %0d seed loads; %0d results checked, %0d mismatches",
             n_seeds, n_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: xorshift32_range_generator.f
design/xrg_pkg.sv
design/xrg_if.sv
design/xorshift32_range_generator.sv
design/xrg_checker.sv
verif/tb_xorshift32_range_generator.sv
